// File: rtl/scc_pkg.sv
// Package with shared types, codes and helper functions of the segment crossing checker.
package scc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int KIND_BITS      = 3;
	localparam int CIDX_BITS      = 3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_FLOOR      = 3'd0,
		KIND_WALL       = 3'd1,
		KIND_TOP        = 3'd2,
		KIND_FLOOR_WALL = 3'd3,
		KIND_TOP_WALL   = 3'd4,
		KIND_TOP_FLOOR  = 3'd5
	} kind_t;

	typedef enum logic [CIDX_BITS-1:0] {
		REG_QUERY_AX   = 3'd0,
		REG_QUERY_AY   = 3'd1,
		REG_QUERY_BX   = 3'd2,
		REG_QUERY_BY   = 3'd3,
		REG_QUERY_KIND = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_POS = 2'd1,
		ORI_NEG = 2'd2
	} orient_t;

	// Per-word results of the first compute stage other than the products.
	typedef struct packed {
		logic win_sa;  // stored first endpoint lies in the query's bounding box
		logic win_sb;  // stored second endpoint lies in the query's bounding box
		logic win_qa;  // query first endpoint lies in the stored bounding box
		logic win_qb;  // query second endpoint lies in the stored bounding box
		logic apart;   // no endpoint is shared exactly
		logic exempt;  // kind pair never blocks
		logic last;
	} geom_flags_t;

	function automatic logic pair_is(input logic [KIND_BITS-1:0] k1, k2,
	                                 input kind_t u, v);
		return (k1 == u && k2 == v) || (k1 == v && k2 == u);
	endfunction

	function automatic logic kind_exempt(input logic [KIND_BITS-1:0] k1, k2);
		return pair_is(k1, k2, KIND_TOP, KIND_FLOOR) ||
		       pair_is(k1, k2, KIND_FLOOR_WALL, KIND_TOP) ||
		       pair_is(k1, k2, KIND_TOP, KIND_WALL) ||
		       pair_is(k1, k2, KIND_TOP_WALL, KIND_FLOOR) ||
		       pair_is(k1, k2, KIND_TOP_FLOOR, KIND_WALL) ||
		       pair_is(k1, k2, KIND_WALL, KIND_FLOOR);
	endfunction

endpackage

// File: rtl/scc_if.sv
// Channel interfaces of the segment crossing checker: stored segments in, results out.
interface scc_seg_if #(
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic signed [COORD_BITS-1:0]       seg_ax;
	logic signed [COORD_BITS-1:0]       seg_ay;
	logic signed [COORD_BITS-1:0]       seg_bx;
	logic signed [COORD_BITS-1:0]       seg_by;
	logic [scc_pkg::KIND_BITS-1:0]      seg_kind;
	logic                               seg_last;

	modport source (output valid, seg_ax, seg_ay, seg_bx, seg_by, seg_kind, seg_last,
	                input ready);
	modport sink (input valid, seg_ax, seg_ay, seg_bx, seg_by, seg_kind, seg_last,
	              output ready);
endinterface

interface scc_res_if;
	logic valid;
	logic ready;
	logic hit_now;
	logic hit_any;
	logic run_done;

	modport source (output valid, hit_now, hit_any, run_done, input ready);
	modport sink (input valid, hit_now, hit_any, run_done, output ready);
endinterface

// File: rtl/segment_crossing_checker.sv
// Top level of the segment crossing checker: query registers, pipeline and run flag.
//
// The query segment and its kind are written through the plain configuration port
// (cfg_we, cfg_idx, cfg_data); the user must write them only while the block is idle,
// which the block does not enforce. Stored segments arrive as words on the seg
// channel; every accepted word yields exactly one word on the res channel, in order:
// hit_now for that segment, hit_any as the OR over the run so far, and run_done as a
// copy of the last mark, at which point hit_any is the run's answer. The run flag is
// cleared after the word that carries the last mark. A word passes an input register,
// a register after the orientation multipliers and the result register, in that order,
// before its result is valid on res.
// Throughput is one word per cycle while the receiver takes results; the eight orientation
// multipliers in the first compute stage set the cycle time.
// Each stage holds its word while the one after it is full, so a stalled receiver
// backs up the pipeline one stage at a time and seg.ready falls only once all three
// stages hold words.
// Reset clears the query registers, the run flag and all valid bits.
module segment_crossing_checker #(
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scc_pkg::CIDX_BITS-1:0]  cfg_idx,
	input  logic [COORD_BITS-1:0]          cfg_data,
	scc_seg_if.sink                        seg,
	scc_res_if.source                      res
);
	import scc_pkg::*;

	localparam int PW = 2 * COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] qax_q, qay_q, qbx_q, qby_q;
	logic [KIND_BITS-1:0]         qkind_q;
	logic                         sticky_q;

	logic                         vld_s1, vld_s2, vld_s3;
	logic                         rdy_s1, rdy_s2, rdy_s3;

	logic signed [COORD_BITS-1:0] sax_s1, say_s1, sbx_s1, sby_s1;
	logic [KIND_BITS-1:0]         kind_s1;
	logic                         last_s1;

	logic signed [PW-1:0]         prod_l_c [4];
	logic signed [PW-1:0]         prod_r_c [4];
	logic signed [PW-1:0]         prod_l_s2 [4];
	logic signed [PW-1:0]         prod_r_s2 [4];
	geom_flags_t                  flags_c, flags_s2;

	logic                         hit_c, sticky_nx;
	logic                         hit_now_s3, hit_any_s3, run_done_s3;

	// Query registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qax_q   <= '0;
			qay_q   <= '0;
			qbx_q   <= '0;
			qby_q   <= '0;
			qkind_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_QUERY_AX:   qax_q   <= cfg_data;
				REG_QUERY_AY:   qay_q   <= cfg_data;
				REG_QUERY_BX:   qbx_q   <= cfg_data;
				REG_QUERY_BY:   qby_q   <= cfg_data;
				REG_QUERY_KIND: qkind_q <= cfg_data[KIND_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign rdy_s3    = !vld_s3 || res.ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign seg.ready = rdy_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && rdy_s1) begin
			sax_s1  <= seg.seg_ax;
			say_s1  <= seg.seg_ay;
			sbx_s1  <= seg.seg_bx;
			sby_s1  <= seg.seg_by;
			kind_s1 <= seg.seg_kind;
			last_s1 <= seg.seg_last;
		end
	end

	scc_prod #(
		.COORD_BITS (COORD_BITS)
	) u_prod (
		.qax        (qax_q),
		.qay        (qay_q),
		.qbx        (qbx_q),
		.qby        (qby_q),
		.query_kind (qkind_q),
		.sax        (sax_s1),
		.say        (say_s1),
		.sbx        (sbx_s1),
		.sby        (sby_s1),
		.seg_kind   (kind_s1),
		.seg_last   (last_s1),
		.prod_l     (prod_l_c),
		.prod_r     (prod_r_c),
		.flags      (flags_c)
	);

	// Product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			prod_l_s2 <= prod_l_c;
			prod_r_s2 <= prod_r_c;
			flags_s2  <= flags_c;
		end
	end

	scc_decide #(
		.COORD_BITS (COORD_BITS)
	) u_decide (
		.prod_l (prod_l_s2),
		.prod_r (prod_r_s2),
		.flags  (flags_s2),
		.hit    (hit_c)
	);

	assign sticky_nx = sticky_q || hit_c;

	// Result register and run flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3   <= 1'b0;
			sticky_q <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (vld_s2 && rdy_s3) begin
				sticky_q <= flags_s2.last ? 1'b0 : sticky_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			hit_now_s3  <= hit_c;
			hit_any_s3  <= sticky_nx;
			run_done_s3 <= flags_s2.last;
		end
	end

	assign res.valid    = vld_s3;
	assign res.hit_now  = hit_now_s3;
	assign res.hit_any  = hit_any_s3;
	assign res.run_done = run_done_s3;

`ifndef SYNTHESIS
	a_hit_in_any: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hit_now |-> res.hit_any)
		else $error("hit reported without the run flag");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && rdy_s3 && flags_s2.last |=> !sticky_q)
		else $error("run flag not cleared after the last word");

	a_exempt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && flags_s2.exempt |-> !hit_c)
		else $error("exempt kind pair reported as a hit");

	a_shared_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !flags_s2.apart |-> !hit_c)
		else $error("shared endpoint reported as a hit");
`endif

endmodule

// File: rtl/scc_prod.sv
// First compute stage: orientation products, bounding box tests, shared endpoints and kinds.
module scc_prod #(
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0]  qax,
	input  logic signed [COORD_BITS-1:0]  qay,
	input  logic signed [COORD_BITS-1:0]  qbx,
	input  logic signed [COORD_BITS-1:0]  qby,
	input  logic [scc_pkg::KIND_BITS-1:0] query_kind,
	input  logic signed [COORD_BITS-1:0]  sax,
	input  logic signed [COORD_BITS-1:0]  say,
	input  logic signed [COORD_BITS-1:0]  sbx,
	input  logic signed [COORD_BITS-1:0]  sby,
	input  logic [scc_pkg::KIND_BITS-1:0] seg_kind,
	input  logic                          seg_last,
	output logic signed [2*COORD_BITS+1:0] prod_l [4],
	output logic signed [2*COORD_BITS+1:0] prod_r [4],
	output scc_pkg::geom_flags_t          flags
);
	import scc_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_BITS-1:0] px [4];
	logic signed [COORD_BITS-1:0] py [4];
	logic signed [COORD_BITS-1:0] tx [4];
	logic signed [COORD_BITS-1:0] ty [4];
	logic signed [COORD_BITS-1:0] rx [4];
	logic signed [COORD_BITS-1:0] ry [4];

	function automatic logic signed [DW-1:0] dif(input logic signed [COORD_BITS-1:0] u, v);
		return DW'(u) - DW'(v);
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] u, v);
		return PW'(u) * PW'(v);
	endfunction

	function automatic logic in_span(input logic signed [COORD_BITS-1:0] p, q, r);
		return (p <= q && q <= r) || (r <= q && q <= p);
	endfunction

	// Turns tested: (qa,qb,sa), (qa,qb,sb), (sa,sb,qa), (sa,sb,qb).
	always_comb begin
		px[0] = qax; py[0] = qay; tx[0] = qbx; ty[0] = qby; rx[0] = sax; ry[0] = say;
		px[1] = qax; py[1] = qay; tx[1] = qbx; ty[1] = qby; rx[1] = sbx; ry[1] = sby;
		px[2] = sax; py[2] = say; tx[2] = sbx; ty[2] = sby; rx[2] = qax; ry[2] = qay;
		px[3] = sax; py[3] = say; tx[3] = sbx; ty[3] = sby; rx[3] = qbx; ry[3] = qby;
		for (int i = 0; i < 4; i++) begin
			prod_l[i] = mul(dif(ty[i], py[i]), dif(rx[i], tx[i]));
			prod_r[i] = mul(dif(tx[i], px[i]), dif(ry[i], ty[i]));
		end
	end

	always_comb begin
		flags.win_sa = in_span(qax, sax, qbx) && in_span(qay, say, qby);
		flags.win_sb = in_span(qax, sbx, qbx) && in_span(qay, sby, qby);
		flags.win_qa = in_span(sax, qax, sbx) && in_span(say, qay, sby);
		flags.win_qb = in_span(sax, qbx, sbx) && in_span(say, qby, sby);
		flags.apart  = !(qax == sbx && qay == sby) && !(qbx == sax && qby == say) &&
		               !(qax == sax && qay == say) && !(qbx == sbx && qby == sby);
		flags.exempt = kind_exempt(seg_kind, query_kind);
		flags.last   = seg_last;
	end

endmodule

// File: rtl/scc_decide.sv
// Second compute stage: orientation signs and the final blocking decision.
module scc_decide #(
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
	input  logic signed [2*COORD_BITS+1:0] prod_l [4],
	input  logic signed [2*COORD_BITS+1:0] prod_r [4],
	input  scc_pkg::geom_flags_t           flags,
	output logic                           hit
);
	import scc_pkg::*;

	localparam int VW = 2 * COORD_BITS + 3;

	orient_t            ori [4];
	logic signed [VW-1:0] turn_v [4];
	logic               crossing;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			turn_v[i] = VW'(prod_l[i]) - VW'(prod_r[i]);
			if (turn_v[i] == '0) begin
				ori[i] = ORI_COL;
			end else if (turn_v[i][VW-1]) begin
				ori[i] = ORI_NEG;
			end else begin
				ori[i] = ORI_POS;
			end
		end
	end

	// Proper crossing, or a collinear endpoint lying on the other segment.
	assign crossing = (ori[0] != ori[1] && ori[2] != ori[3]) ||
	                  (ori[0] == ORI_COL && flags.win_sa) ||
	                  (ori[1] == ORI_COL && flags.win_sb) ||
	                  (ori[2] == ORI_COL && flags.win_qa) ||
	                  (ori[3] == ORI_COL && flags.win_qb);

	assign hit = crossing && flags.apart && !flags.exempt;

endmodule
